// File: design/cbsc_pkg.sv
`default_nettype none

package cbsc_pkg;

   localparam int unsigned MAX_CHUNKS  = 256;
   localparam int unsigned CLASS_COUNT = 5;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned CLASS_IDX_W = $clog2(CLASS_COUNT);

   typedef enum logic [1:0] {
      VERDICT_PENDING = 2'd0,
      VERDICT_VALID   = 2'd1,
      VERDICT_INVALID = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0]  avail_class;
      logic [31:0] chunk_position;
      logic [63:0] chunk_batch;
      logic [63:0] bundle_batch;
      logic [63:0] offset_in_class;
      logic [31:0] declared_length;
      logic [31:0] span_length;
      logic        span_absent;
      logic [63:0] bundle_total;
      logic        last_chunk;
   } req_type;

   typedef struct packed {
      verdict_type         verdict;
      logic                is_final;
      logic [COUNT_W-1:0]  chunks_counted;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/chunk_bundle_sequence_checker.sv
// Checks that a stream of chunk descriptors forms a well-formed bundle.
// The request channel (req_valid, req_stall, req_data) carries one chunk
// descriptor per transaction; the response channel (rsp_valid, rsp_stall,
// rsp_data) returns exactly one result per descriptor, in order.
// Each descriptor is captured in an input register, checked against the
// per-class offset, running total and sequence registers, and its result
// lands in the output register once that is empty or being emptied. One
// descriptor can be taken every cycle while the receiver does not stall;
// the per-class offset and running total registers are updated as each
// result is loaded into the output register.
// The result on the descriptor marked last carries the final verdict and
// is_final, after which all bundle state returns to its cleared value.
// Reset empties both registers and clears all bundle state.
// While the receiver stalls a waiting result, one more descriptor can still
// be taken into the input register; after that req_stall is raised until the
// result is taken.
`default_nettype none

module chunk_bundle_sequence_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cbsc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cbsc_pkg::rsp_type      rsp_data
);

   logic              s1_valid_ff, s1_valid_in;
   cbsc_pkg::req_type s1_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cbsc_pkg::rsp_type rsp_data_ff;
   cbsc_pkg::rsp_type core_result;
   logic              rsp_load;
   logic              step;
   logic              req_fire;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && rsp_load;
   assign req_stall = s1_valid_ff && !rsp_load;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_load ? step : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= core_result;
      end
   end

   cbsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item_ff),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("held descriptor not blocking new transactions");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_final |-> rsp_data.verdict != cbsc_pkg::VERDICT_PENDING)
      else $error("final result without a verdict");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_final |-> rsp_data.verdict != cbsc_pkg::VERDICT_VALID)
      else $error("bundle declared valid before its last chunk");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.chunks_counted != '0)
      else $error("result with zero chunk count");

endmodule

`default_nettype wire

// File: design/cbsc_core.sv
`default_nettype none

module cbsc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire cbsc_pkg::req_type item,
   output cbsc_pkg::rsp_type      result
);

   logic [63:0] offsets_ff [cbsc_pkg::CLASS_COUNT];
   logic [63:0] offsets_in [cbsc_pkg::CLASS_COUNT];
   logic [63:0] total_ff, total_in;
   logic [cbsc_pkg::CLASS_COUNT-1:0] seen_ff, seen_in;
   logic [cbsc_pkg::CLASS_IDX_W-1:0] prior_class_ff, prior_class_in;
   logic prior_empty_ff, prior_empty_in;
   logic [cbsc_pkg::COUNT_W-1:0] counter_ff, counter_in;
   logic failed_ff, failed_in;

   logic [cbsc_pkg::COUNT_W-1:0] count;
   logic over;
   logic cls_ok;
   logic [cbsc_pkg::CLASS_IDX_W-1:0] ci;
   logic [63:0] cur_off;
   logic [cbsc_pkg::CLASS_COUNT-1:0] cls_bit;
   logic len_zero;
   logic fail_early;
   logic bad;
   logic fail_all;
   logic update;
   logic [63:0] new_off;
   logic [63:0] new_total;
   logic [63:0] total_after;
   logic [cbsc_pkg::CLASS_COUNT-1:0] seen_after;
   logic ok;

   always_comb begin
      if (counter_ff > cbsc_pkg::COUNT_W'(cbsc_pkg::MAX_CHUNKS)) begin
         count = counter_ff;
      end else begin
         count = counter_ff + cbsc_pkg::COUNT_W'(1);
      end
      over = count > cbsc_pkg::COUNT_W'(cbsc_pkg::MAX_CHUNKS);

      cls_ok = (item.avail_class >= 8'd1) &&
               (item.avail_class <= 8'(cbsc_pkg::CLASS_COUNT));
      ci = item.avail_class[cbsc_pkg::CLASS_IDX_W-1:0] - cbsc_pkg::CLASS_IDX_W'(1);

      cur_off = '0;
      for (int k = 0; k < cbsc_pkg::CLASS_COUNT; k++) begin
         if (ci == cbsc_pkg::CLASS_IDX_W'(k)) begin
            cur_off = offsets_ff[k];
         end
      end
      cls_bit = cbsc_pkg::CLASS_COUNT'(1) << ci;
      len_zero = item.declared_length == 32'd0;

      fail_early = failed_ff || over || !cls_ok ||
                   (prior_empty_ff &&
                    item.avail_class == 8'(prior_class_ff));

      bad = (item.avail_class < 8'(prior_class_ff)) ||
            (item.chunk_position != 32'(counter_ff)) ||
            (item.chunk_batch != item.bundle_batch) ||
            (item.offset_in_class != cur_off) ||
            (item.declared_length != item.span_length) ||
            (item.span_absent && !len_zero) ||
            (len_zero && ((seen_ff & cls_bit) != '0));

      fail_all = fail_early || bad;
      update   = !fail_all;

      new_off   = cur_off + 64'(item.declared_length);
      new_total = total_ff + 64'(item.declared_length);

      total_after = update ? new_total : total_ff;
      seen_after  = update ? (seen_ff | cls_bit) : seen_ff;

      ok = !fail_all &&
           (count >= cbsc_pkg::COUNT_W'(cbsc_pkg::CLASS_COUNT)) &&
           (count <= cbsc_pkg::COUNT_W'(cbsc_pkg::MAX_CHUNKS)) &&
           (&seen_after) &&
           (total_after == item.bundle_total);

      result.is_final       = item.last_chunk;
      result.chunks_counted = count;
      if (item.last_chunk) begin
         result.verdict = ok ? cbsc_pkg::VERDICT_VALID : cbsc_pkg::VERDICT_INVALID;
      end else begin
         result.verdict = fail_all ? cbsc_pkg::VERDICT_INVALID
                                   : cbsc_pkg::VERDICT_PENDING;
      end
   end

   always_comb begin
      offsets_in     = offsets_ff;
      total_in       = total_ff;
      seen_in        = seen_ff;
      prior_class_in = prior_class_ff;
      prior_empty_in = prior_empty_ff;
      counter_in     = counter_ff;
      failed_in      = failed_ff;
      if (step) begin
         if (item.last_chunk) begin
            for (int k = 0; k < cbsc_pkg::CLASS_COUNT; k++) begin
               offsets_in[k] = '0;
            end
            total_in       = '0;
            seen_in        = '0;
            prior_class_in = '0;
            prior_empty_in = 1'b0;
            counter_in     = '0;
            failed_in      = 1'b0;
         end else begin
            counter_in = count;
            failed_in  = fail_all;
            if (update) begin
               for (int k = 0; k < cbsc_pkg::CLASS_COUNT; k++) begin
                  if (ci == cbsc_pkg::CLASS_IDX_W'(k)) begin
                     offsets_in[k] = new_off;
                  end
               end
               total_in       = new_total;
               seen_in        = seen_ff | cls_bit;
               prior_class_in = item.avail_class[cbsc_pkg::CLASS_IDX_W-1:0];
               prior_empty_in = len_zero;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cbsc_pkg::CLASS_COUNT; k++) begin
            offsets_ff[k] <= '0;
         end
         total_ff       <= '0;
         seen_ff        <= '0;
         prior_class_ff <= '0;
         prior_empty_ff <= 1'b0;
         counter_ff     <= '0;
         failed_ff      <= 1'b0;
      end else begin
         offsets_ff     <= offsets_in;
         total_ff       <= total_in;
         seen_ff        <= seen_in;
         prior_class_ff <= prior_class_in;
         prior_empty_ff <= prior_empty_in;
         counter_ff     <= counter_in;
         failed_ff      <= failed_in;
      end
   end

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned PHASE_ITEMS = 72;
   localparam int unsigned HOLD_OFF_CYCLES = 60;

   typedef enum int {
      FAULT_NONE,
      FAULT_CLASS,
      FAULT_POSITION,
      FAULT_BATCH,
      FAULT_OFFSET,
      FAULT_SPAN,
      FAULT_ABSENT,
      FAULT_TOTAL,
      FAULT_EARLY_LAST,
      FAULT_EMPTY
   } fault_kind_type;

   class bundle_verdict_model;
      logic [63:0]                      offset_by_class [cbsc_pkg::CLASS_COUNT];
      logic [63:0]                      byte_sum;
      logic [cbsc_pkg::CLASS_COUNT-1:0] classes_present;
      logic [7:0]                       last_class;
      bit                               last_was_empty;
      int unsigned                      taken;
      bit                               broken;
      cbsc_pkg::rsp_type                verdicts_due [$];
      int unsigned                      mismatch_count;

      function new();
         mismatch_count = 0;
         clear_bundle();
      endfunction

      function void clear_bundle();
         foreach (offset_by_class[c]) offset_by_class[c] = '0;
         byte_sum = '0;
         classes_present = '0;
         last_class = '0;
         last_was_empty = 1'b0;
         taken = 0;
         broken = 1'b0;
      endfunction

      function void take_descriptor(cbsc_pkg::req_type r);
         int unsigned cnt;
         int unsigned ci;
         bit whole_ok;
         cbsc_pkg::rsp_type e;
         cnt = (taken > cbsc_pkg::MAX_CHUNKS) ? taken : taken + 1;
         if (cnt > cbsc_pkg::MAX_CHUNKS) broken = 1'b1;
         if (!broken) begin
            if (last_was_empty && r.avail_class == last_class) broken = 1'b1;
            if (r.avail_class < 1 || r.avail_class > cbsc_pkg::CLASS_COUNT) broken = 1'b1;
         end
         if (!broken) begin
            ci = r.avail_class - 8'd1;
            if (r.avail_class < last_class || r.chunk_position != taken ||
                r.chunk_batch != r.bundle_batch ||
                r.offset_in_class != offset_by_class[ci] ||
                r.declared_length != r.span_length ||
                (r.span_absent && r.declared_length != 0) ||
                (r.declared_length == 0 && classes_present[ci])) begin
               broken = 1'b1;
            end else begin
               offset_by_class[ci] += 64'(r.declared_length);
               byte_sum += 64'(r.declared_length);
               classes_present[ci] = 1'b1;
               last_class = r.avail_class;
               last_was_empty = (r.declared_length == 0);
            end
         end
         taken = cnt;
         e.is_final = r.last_chunk;
         e.chunks_counted = cnt[cbsc_pkg::COUNT_W-1:0];
         if (r.last_chunk) begin
            whole_ok = !broken && cnt >= cbsc_pkg::CLASS_COUNT &&
                       cnt <= cbsc_pkg::MAX_CHUNKS &&
                       (&classes_present) && byte_sum == r.bundle_total;
            if (whole_ok) e.verdict = cbsc_pkg::VERDICT_VALID;
            else e.verdict = cbsc_pkg::VERDICT_INVALID;
            clear_bundle();
         end else if (broken) begin
            e.verdict = cbsc_pkg::VERDICT_INVALID;
         end else begin
            e.verdict = cbsc_pkg::VERDICT_PENDING;
         end
         verdicts_due.push_back(e);
      endfunction

      function void match_verdict(cbsc_pkg::rsp_type got);
         cbsc_pkg::rsp_type want;
         if (verdicts_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: verdict %0d final %0b count %0d",
                        got.verdict, got.is_final, got.chunks_counted);
            return;
         end
         want = verdicts_due.pop_front();
         if (got.verdict !== want.verdict || got.is_final !== want.is_final ||
             got.chunks_counted !== want.chunks_counted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected verdict %0d final %0b count %0d, ",
                        "got verdict %0d final %0b count %0d",
                        want.verdict, want.is_final, want.chunks_counted,
                        got.verdict, got.is_final, got.chunks_counted);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   cbsc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   cbsc_pkg::rsp_type rsp_data;

   bundle_verdict_model board = new();

   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          hold_off_request = 1'b0;
   int unsigned descriptors_sent = 0;
   int unsigned cycle_count = 0;

   chunk_bundle_sequence_checker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("chunk_bundle_sequence_checker verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.match_verdict(rsp_data);
   end

   // A long hold-off lets the block fill up and push back on its input.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_item(input cbsc_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_descriptor(item);
      descriptors_sent++;
   endtask

   task automatic send_noise(input int unsigned count);
      cbsc_pkg::req_type item;
      for (int unsigned i = 0; i < count; i++) begin
         item.avail_class = $urandom_range(1)
                            ? 8'($urandom_range(1, cbsc_pkg::CLASS_COUNT))
                            : 8'($urandom);
         item.chunk_position = $urandom_range(1) ? i : $urandom;
         item.chunk_batch = {$urandom, $urandom};
         item.bundle_batch = $urandom_range(1) ? item.chunk_batch : {$urandom, $urandom};
         item.offset_in_class = {$urandom, $urandom};
         item.declared_length = $urandom;
         item.span_length = $urandom_range(1) ? item.declared_length : $urandom;
         item.span_absent = 1'($urandom_range(1));
         item.bundle_total = {$urandom, $urandom};
         item.last_chunk = (i == count - 1);
         send_item(item);
      end
   endtask

   task automatic send_bundle(input int unsigned n, input fault_kind_type fault);
      int unsigned       per_class [cbsc_pkg::CLASS_COUNT];
      logic [63:0]       offs [cbsc_pkg::CLASS_COUNT];
      logic [63:0]       batch;
      logic [63:0]       total;
      logic [63:0]       flip;
      logic [31:0]       len;
      cbsc_pkg::req_type plan [$];
      cbsc_pkg::req_type item;
      int unsigned       k;
      foreach (per_class[c]) begin
         per_class[c] = (n >= cbsc_pkg::CLASS_COUNT) ? 1 : 0;
         offs[c] = '0;
      end
      repeat ((n >= cbsc_pkg::CLASS_COUNT) ? n - cbsc_pkg::CLASS_COUNT : n)
         per_class[$urandom_range(cbsc_pkg::CLASS_COUNT - 1)]++;
      case ($urandom_range(7))
         0: batch = '0;
         1: batch = '1;
         default: batch = {$urandom, $urandom};
      endcase
      total = '0;
      for (int unsigned c = 0; c < cbsc_pkg::CLASS_COUNT; c++) begin
         for (int unsigned j = 0; j < per_class[c]; j++) begin
            if (per_class[c] == 1 && $urandom_range(3) == 0) len = '0;
            else if ($urandom_range(7) == 0) len = $urandom;
            else len = $urandom_range(1, 4000);
            item = '0;
            item.avail_class = 8'(c + 1);
            item.chunk_position = plan.size();
            item.chunk_batch = batch;
            item.bundle_batch = batch;
            item.offset_in_class = offs[c];
            item.declared_length = len;
            item.span_length = len;
            item.span_absent = (len == 0) ? 1'($urandom_range(1)) : 1'b0;
            plan.push_back(item);
            offs[c] += 64'(len);
            total += 64'(len);
         end
      end
      foreach (plan[i]) plan[i].bundle_total = total;
      plan[plan.size() - 1].last_chunk = 1'b1;
      k = $urandom_range(plan.size() - 1);
      flip = 64'd1 << $urandom_range(63);
      case (fault)
         FAULT_CLASS: plan[k].avail_class = 8'($urandom);
         FAULT_POSITION: plan[k].chunk_position ^= flip[31:0] | (32'd1 << $urandom_range(31));
         FAULT_BATCH: plan[k].chunk_batch ^= flip;
         FAULT_OFFSET: plan[k].offset_in_class ^= flip;
         FAULT_SPAN: plan[k].span_length ^= 32'd1 << $urandom_range(31);
         FAULT_ABSENT: plan[k].span_absent = 1'b1;
         FAULT_TOTAL: foreach (plan[i]) plan[i].bundle_total ^= flip;
         FAULT_EARLY_LAST: begin
            plan[k].last_chunk = 1'b1;
            while (plan.size() > k + 1) void'(plan.pop_back());
         end
         FAULT_EMPTY: begin
            plan[k].declared_length = '0;
            plan[k].span_length = '0;
         end
         default: ;
      endcase
      foreach (plan[i]) send_item(plan[i]);
   endtask

   initial begin : stimulus
      cbsc_pkg::req_type base;
      cbsc_pkg::req_type item;
      logic [31:0]       extreme_len [cbsc_pkg::CLASS_COUNT];
      logic [63:0]       extreme_total;
      logic [63:0]       extreme_batch;
      int unsigned       phase_start;
      int unsigned       roll;
      int unsigned       n;
      fault_kind_type    fault;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      base = '0;
      base.avail_class = 8'd1;
      base.chunk_batch = 64'h0123_4567_89AB_CDEF;
      base.bundle_batch = 64'h0123_4567_89AB_CDEF;
      base.declared_length = 32'd16;
      base.span_length = 32'd16;
      base.bundle_total = 64'd16;
      base.last_chunk = 1'b1;

      item = base; item.chunk_position = 32'd1; send_item(item);
      item = base; item.chunk_batch ^= 64'd1; send_item(item);
      item = base; item.offset_in_class = 64'd8; send_item(item);
      item = base; item.span_length = 32'd17; send_item(item);
      item = base; item.span_absent = 1'b1; send_item(item);
      item = base; item.avail_class = 8'd0; send_item(item);
      item = base; item.avail_class = 8'd6; send_item(item);
      item = base; item.avail_class = 8'hFF; send_item(item);
      item = '1; send_item(item);
      item = '0; send_item(item);

      item = base; item.avail_class = 8'd2; item.last_chunk = 1'b0; send_item(item);
      item = base; item.chunk_position = 32'd1; send_item(item);

      item = base; item.declared_length = '0; item.span_length = '0;
      item.bundle_total = '0; item.last_chunk = 1'b0; send_item(item);
      item.chunk_position = 32'd1; item.last_chunk = 1'b1; send_item(item);

      item = base; item.avail_class = 8'd0; item.last_chunk = 1'b0; send_item(item);
      item = base; item.chunk_position = 32'd1; item.last_chunk = 1'b0; send_item(item);
      item = base; item.chunk_position = 32'd2; send_item(item);

      extreme_len[0] = 32'hFFFF_FFFF;
      extreme_len[1] = 32'h0;
      extreme_len[2] = 32'h1;
      extreme_len[3] = 32'hFFFF_FFFF;
      extreme_len[4] = 32'h7FFF_FFFF;
      extreme_total = '0;
      extreme_batch = '1;
      foreach (extreme_len[c]) extreme_total += 64'(extreme_len[c]);
      for (int unsigned c = 0; c < cbsc_pkg::CLASS_COUNT; c++) begin
         item = '0;
         item.avail_class = 8'(c + 1);
         item.chunk_position = c;
         item.chunk_batch = extreme_batch;
         item.bundle_batch = extreme_batch;
         item.declared_length = extreme_len[c];
         item.span_length = extreme_len[c];
         item.span_absent = (extreme_len[c] == 0);
         item.bundle_total = extreme_total;
         item.last_chunk = (c == cbsc_pkg::CLASS_COUNT - 1);
         send_item(item);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 55; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 55; end
            default: begin sender_idle_pct = 24; stall_pct = 24; end
         endcase
         if (phase == 0 || phase == 2) hold_off_request = 1'b1;
         if (phase == 1) send_bundle(cbsc_pkg::MAX_CHUNKS, FAULT_NONE);
         if (phase == 3) send_bundle(cbsc_pkg::MAX_CHUNKS + 3, FAULT_NONE);
         phase_start = descriptors_sent;
         while (descriptors_sent - phase_start < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               send_noise($urandom_range(1, 3));
            end else begin
               if (roll < 70) n = $urandom_range(cbsc_pkg::CLASS_COUNT, 12);
               else if (roll < 88) n = $urandom_range(13, 40);
               else n = $urandom_range(1, cbsc_pkg::CLASS_COUNT - 1);
               if ($urandom_range(99) < 55) fault = FAULT_NONE;
               else fault = fault_kind_type'($urandom_range(FAULT_CLASS, FAULT_EMPTY));
               send_bundle(n, fault);
            end
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.verdicts_due.size() == 0)
         $display("chunk_bundle_sequence_checker verification clean");
      else
         $display("chunk_bundle_sequence_checker verification failed");
      $finish;
   end

endmodule
